// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising edge outside reset
`define LPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// condition must never be true outside reset
`define LPS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define LPS_ASSERT(lbl, clk, rstn, prop)
`define LPS_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- rtl/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg
// constants, register map and pattern tables of the led pattern sequencer
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned LPS_ADDR_W = 4;
  localparam int unsigned LPS_DATA_W = 32;
  localparam int unsigned LPS_NUM_BTN = 3;
  localparam int unsigned LPS_NUM_PROG = 4;

  // button slots in the raw level vector
  localparam int unsigned BTN_RUN   = 0;
  localparam int unsigned BTN_PROG  = 1;
  localparam int unsigned BTN_SPEED = 2;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SLOW_PERIOD   = 2'd0,
    REG_FAST_PERIOD   = 2'd1,
    REG_DEBOUNCE_NEED = 2'd2
  } lps_reg_e;

  localparam logic [7:0] SLOW_PERIOD_RST   = 8'd200;
  localparam logic [7:0] FAST_PERIOD_RST   = 8'd100;
  localparam logic [7:0] DEBOUNCE_NEED_RST = 8'd5;
  localparam logic [2:0] PROG_FIRST        = 3'd1;
  localparam logic [2:0] PROG_LAST         = 3'd4;

  // number of entries in each program's pattern
  function automatic logic [3:0] pat_len(input logic [1:0] prog);
    logic [3:0] len;
    case (prog)
      2'd0:    len = 4'd2;
      2'd1:    len = 4'd8;
      2'd2:    len = 4'd6;
      default: len = 4'd4;
    endcase
    return len;
  endfunction

  // pattern entry of a program
  function automatic logic [7:0] pat_byte(input logic [1:0] prog, input logic [2:0] idx);
    logic [7:0] val;
    val = 8'h00;
    case (prog)
      2'd0: begin
        val = idx[0] ? 8'hFF : 8'h00;
      end
      2'd1: begin
        val = 8'h01 << idx;
      end
      2'd2: begin
        case (idx)
          3'd0:    val = 8'h81;
          3'd1:    val = 8'h42;
          3'd2:    val = 8'h24;
          3'd3:    val = 8'h18;
          3'd4:    val = 8'h24;
          3'd5:    val = 8'h42;
          default: val = 8'h81;
        endcase
      end
      default: begin
        case (idx[1:0])
          2'd0:    val = 8'h88;
          2'd1:    val = 8'h44;
          2'd2:    val = 8'h22;
          default: val = 8'h11;
        endcase
      end
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/lps_in_if.sv -----
// ----------------------------------------------------------------------------
// lps_in_if
// tick channel carrying the three raw button levels
// ----------------------------------------------------------------------------
interface lps_in_if;
  logic valid;
  logic ready;
  logic run_button;
  logic program_button;
  logic speed_button;

  modport source (output valid, output run_button, output program_button,
                  output speed_button, input ready);
  modport sink (input valid, input run_button, input program_button,
                input speed_button, output ready);
endinterface

// ----- rtl/lps_out_if.sv -----
// ----------------------------------------------------------------------------
// lps_out_if
// result channel carrying the led byte and the sequencer status
// ----------------------------------------------------------------------------
interface lps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_byte;
  logic       is_running;
  logic [2:0] program_now;
  logic       fast_mode;

  modport source (output valid, output led_byte, output is_running,
                  output program_now, output fast_mode, input ready);
  modport sink (input valid, input led_byte, input is_running,
                input program_now, input fast_mode, output ready);
endinterface

// ----- rtl/led_pattern_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// led_pattern_sequencer_top
// led chaser sequencer: one transaction per timer tick, one result each
// ----------------------------------------------------------------------------
//   channel  | dir | handshake          | payload
//   in_i     | in  | valid/ready        | run_button, program_button, speed_button
//   out_o    | out | valid/ready        | led_byte, is_running, program_now, fast_mode
//   apb      | in  | psel/penable/pready| slow_period, fast_period, debounce_need
//
// one tick per clock sustained while results are taken; a tick waits in the input register,
// then the tick logic updates all state and the result register together
// result is registered at the same edge at which the tick leaves the input register
// a stalled output holds the result; the input register still takes one tick
// reset (async, active low) restores registers and all sequencer state
`include "assert_macros.svh"

module led_pattern_sequencer_top import lps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lps_in_if.sink                in_i,
  lps_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [LPS_ADDR_W-1:0] paddr,
  input  logic [LPS_DATA_W-1:0] pwdata,
  output logic [LPS_DATA_W-1:0] prdata,
  output logic                  pready
);

  // configuration registers
  logic [7:0] slow_q, fast_q, need_q;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // input register
  logic                   s1_vld_q;
  logic [LPS_NUM_BTN-1:0] s1_raw_q;
  logic                   s1_adv;
  logic                   in_acc;

  // sequencer state; run/prog/speed/led double as the result payload
  logic [7:0]             tick_q, tick_d;
  logic                   pend_q, pend_d;
  logic [LPS_NUM_BTN-1:0] last_q, last_d;
  logic [LPS_NUM_BTN-1:0] stable_q, stable_d;
  logic [7:0]             cnt_q [LPS_NUM_BTN];
  logic [7:0]             cnt_d [LPS_NUM_BTN];
  logic [7:0]             cnt_inc [LPS_NUM_BTN];
  logic [LPS_NUM_BTN-1:0] fall;
  logic                   run_q, run_d;
  logic [2:0]             prog_q, prog_d;
  logic                   speed_q, speed_d;
  logic [3:0]             pidx_q [LPS_NUM_PROG];
  logic [3:0]             pidx_d [LPS_NUM_PROG];
  logic [7:0]             led_q, led_d;
  logic                   out_vld_q;

  // tick datapath temporaries
  logic [7:0] period;
  logic [1:0] sel;
  logic [3:0] idx_cur, idx_use;
  logic [2:0] prog_m1;

  // ---------------------------------------------------------------------------
  // apb port: writes land on the access cycle, no wait states
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[LPS_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q <= SLOW_PERIOD_RST;
      fast_q <= FAST_PERIOD_RST;
      need_q <= DEBOUNCE_NEED_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SLOW_PERIOD:   slow_q <= pwdata[7:0];
        REG_FAST_PERIOD:   fast_q <= pwdata[7:0];
        REG_DEBOUNCE_NEED: need_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SLOW_PERIOD:   prdata = {{(LPS_DATA_W-8){1'b0}}, slow_q};
      REG_FAST_PERIOD:   prdata = {{(LPS_DATA_W-8){1'b0}}, fast_q};
      REG_DEBOUNCE_NEED: prdata = {{(LPS_DATA_W-8){1'b0}}, need_q};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: input register drains into the result register whenever the
  // result slot is empty or being taken this cycle
  // ---------------------------------------------------------------------------
  assign s1_adv     = s1_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready = ~s1_vld_q | s1_adv;
  assign in_acc     = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_raw_q[BTN_RUN]   <= in_i.run_button;
      s1_raw_q[BTN_PROG]  <= in_i.program_button;
      s1_raw_q[BTN_SPEED] <= in_i.speed_button;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // tick logic
  // ---------------------------------------------------------------------------
  always_comb begin
    // step timer, period chosen by the speed in effect at tick start
    period = speed_q ? fast_q : slow_q;
    tick_d = tick_q + 8'd1;
    pend_d = pend_q;
    if (tick_d == period) begin
      tick_d = '0;
      pend_d = 1'b1;
    end

    // debounce: a level is taken after need_q repeated equal samples
    for (int b = 0; b < LPS_NUM_BTN; b++) begin
      cnt_inc[b]  = cnt_q[b] + 8'd1;
      stable_d[b] = stable_q[b];
      last_d[b]   = s1_raw_q[b];
      if (s1_raw_q[b] == last_q[b]) begin
        if (cnt_inc[b] >= need_q) begin
          stable_d[b] = s1_raw_q[b];
          cnt_d[b]    = '0;
        end else begin
          cnt_d[b] = cnt_inc[b];
        end
      end else begin
        cnt_d[b] = '0;
      end
      // press is a high to low change of the debounced level
      fall[b] = stable_q[b] & ~stable_d[b];
    end

    run_d = run_q ^ fall[BTN_RUN];
    if (fall[BTN_RUN] && run_d) begin
      tick_d = '0;
    end
    speed_d = speed_q ^ fall[BTN_SPEED];
    prog_d  = prog_q;
    if (fall[BTN_PROG]) begin
      prog_d = (prog_q >= PROG_LAST || prog_q == 3'd0) ? PROG_FIRST : prog_q + 3'd1;
    end

    // pattern step on the program selected after this tick's presses
    prog_m1 = prog_d - 3'd1;
    sel     = prog_m1[1:0];
    idx_cur = pidx_q[sel];
    idx_use = (idx_cur >= pat_len(sel)) ? 4'd0 : idx_cur;
    pidx_d  = pidx_q;
    led_d   = led_q;
    if (run_d) begin
      if (pend_d) begin
        led_d       = pat_byte(sel, idx_use[2:0]);
        pidx_d[sel] = idx_use + 4'd1;
        pend_d      = 1'b0;
      end
    end else begin
      led_d = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      pend_q   <= 1'b0;
      last_q   <= '1;
      stable_q <= '1;
      for (int b = 0; b < LPS_NUM_BTN; b++) begin
        cnt_q[b] <= '0;
      end
      run_q   <= 1'b0;
      prog_q  <= PROG_FIRST;
      speed_q <= 1'b0;
      for (int p = 0; p < LPS_NUM_PROG; p++) begin
        pidx_q[p] <= '0;
      end
      led_q <= '0;
    end else if (s1_adv) begin
      tick_q   <= tick_d;
      pend_q   <= pend_d;
      last_q   <= last_d;
      stable_q <= stable_d;
      cnt_q    <= cnt_d;
      run_q    <= run_d;
      prog_q   <= prog_d;
      speed_q  <= speed_d;
      pidx_q   <= pidx_d;
      led_q    <= led_d;
    end
  end

  // result payload comes straight from the state registers
  assign out_o.valid       = out_vld_q;
  assign out_o.led_byte    = led_q;
  assign out_o.is_running  = run_q;
  assign out_o.program_now = prog_q;
  assign out_o.fast_mode   = speed_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `LPS_ASSERT(a_prog_range, clk_i, rst_ni, (prog_q != 3'd0) && (prog_q <= PROG_LAST))
  `LPS_ASSERT(a_led_dark_when_stopped, clk_i, rst_ni, !run_q |-> (led_q == 8'h00))
  `LPS_ASSERT(a_adv_gives_result, clk_i, rst_ni, s1_adv |=> out_vld_q)
  `LPS_ASSERT(a_stall_cause, clk_i, rst_ni, !in_i.ready |-> (s1_vld_q && out_vld_q))
  `LPS_ASSERT_NEVER(a_prog1_index, clk_i, rst_ni, pidx_q[0] > 4'd2)

endmodule

// ----- tb/sv/led_pattern_sequencer_top_test.sv -----
// ----------------------------------------------------------------------------
// led_pattern_sequencer_top_test
// drives button ticks into the sequencer, programs its periods and debounce
// depth over apb, and compares every result transaction against a cycle-free
// model of the chaser kept inside a small scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] led_byte;
  logic       is_running;
  logic [2:0] program_now;
  logic       fast_mode;
} seq_status_t;

class chaser_scoreboard;
  logic [7:0]  slow_period;
  logic [7:0]  fast_period;
  logic [7:0]  debounce_need;
  logic [7:0]  tick_count;
  logic        step_due;
  logic [2:0]  last_raw;
  logic [2:0]  stable_lvl;
  logic [2:0]  prior_lvl;
  logic [7:0]  repeat_cnt [3];
  logic        running;
  logic        fast_sel;
  logic [2:0]  prog_sel;
  logic [3:0]  pat_pos [4];
  logic [7:0]  led_now;
  seq_status_t expected_status [$];
  int unsigned failures;

  function new();
    slow_period   = lps_pkg::SLOW_PERIOD_RST;
    fast_period   = lps_pkg::FAST_PERIOD_RST;
    debounce_need = lps_pkg::DEBOUNCE_NEED_RST;
    tick_count    = '0;
    step_due      = 1'b0;
    last_raw      = '1;
    stable_lvl    = '1;
    prior_lvl     = '1;
    foreach (repeat_cnt[b]) repeat_cnt[b] = '0;
    running       = 1'b0;
    fast_sel      = 1'b0;
    prog_sel      = lps_pkg::PROG_FIRST;
    foreach (pat_pos[p]) pat_pos[p] = '0;
    led_now       = '0;
    failures      = 0;
  endfunction

  function void set_reg(input lps_pkg::lps_reg_e idx, input logic [7:0] val);
    case (idx)
      lps_pkg::REG_SLOW_PERIOD:   slow_period = val;
      lps_pkg::REG_FAST_PERIOD:   fast_period = val;
      lps_pkg::REG_DEBOUNCE_NEED: debounce_need = val;
      default: ;
    endcase
  endfunction

  function int unsigned pattern_len(input logic [1:0] slot);
    int unsigned len;
    case (slot)
      2'd0:    len = 2;
      2'd1:    len = 8;
      2'd2:    len = 6;
      default: len = 4;
    endcase
    return len;
  endfunction

  function logic [7:0] pattern_step(input logic [1:0] slot, input logic [3:0] pos);
    logic [7:0] blink [2];
    logic [7:0] walk [8];
    logic [7:0] bounce [6];
    logic [7:0] diag [4];
    logic [7:0] val;
    blink  = '{8'h00, 8'hFF};
    walk   = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
    bounce = '{8'h81, 8'h42, 8'h24, 8'h18, 8'h24, 8'h42};
    diag   = '{8'h88, 8'h44, 8'h22, 8'h11};
    case (slot)
      2'd0:    val = blink[pos];
      2'd1:    val = walk[pos];
      2'd2:    val = bounce[pos];
      default: val = diag[pos];
    endcase
    return val;
  endfunction

  // one accepted tick: advance the model and queue its status
  function void note_tick(input logic [2:0] raw);
    logic [7:0]  period;
    logic [1:0]  slot;
    seq_status_t res;
    tick_count = tick_count + 8'd1;
    period = fast_sel ? fast_period : slow_period;
    if (tick_count == period) begin
      tick_count = '0;
      step_due = 1'b1;
    end
    for (int b = 0; b < 3; b++) begin
      if (raw[b] == last_raw[b]) begin
        repeat_cnt[b] = repeat_cnt[b] + 8'd1;
        if (repeat_cnt[b] >= debounce_need) begin
          stable_lvl[b] = raw[b];
          repeat_cnt[b] = '0;
        end
      end else begin
        repeat_cnt[b] = '0;
      end
      last_raw[b] = raw[b];
    end
    if (prior_lvl[lps_pkg::BTN_RUN] && !stable_lvl[lps_pkg::BTN_RUN]) begin
      running = !running;
      if (running) tick_count = '0;
    end
    if (prior_lvl[lps_pkg::BTN_SPEED] && !stable_lvl[lps_pkg::BTN_SPEED])
      fast_sel = !fast_sel;
    if (prior_lvl[lps_pkg::BTN_PROG] && !stable_lvl[lps_pkg::BTN_PROG]) begin
      prog_sel = prog_sel + 3'd1;
      if (prog_sel > lps_pkg::PROG_LAST || prog_sel == 3'd0) prog_sel = lps_pkg::PROG_FIRST;
    end
    prior_lvl = stable_lvl;
    if (running) begin
      if (step_due) begin
        slot = prog_sel[1:0] - 2'd1;
        if (pat_pos[slot] >= pattern_len(slot)) pat_pos[slot] = '0;
        led_now = pattern_step(slot, pat_pos[slot]);
        pat_pos[slot] = pat_pos[slot] + 4'd1;
        step_due = 1'b0;
      end
    end else begin
      led_now = '0;
    end
    res.led_byte    = led_now;
    res.is_running  = running;
    res.program_now = prog_sel;
    res.fast_mode   = fast_sel;
    expected_status.push_back(res);
  endfunction

  function void check_status(input seq_status_t got);
    seq_status_t want;
    if (expected_status.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: led %02h run %0d prog %0d fast %0d",
                 got.led_byte, got.is_running, got.program_now, got.fast_mode);
      return;
    end
    want = expected_status.pop_front();
    if (got.led_byte !== want.led_byte || got.is_running !== want.is_running ||
        got.program_now !== want.program_now || got.fast_mode !== want.fast_mode) begin
      failures++;
      if (failures <= 10) begin
        $write("mismatch: exp led %02h run %0d prog %0d fast %0d,",
               want.led_byte, want.is_running, want.program_now, want.fast_mode);
        $display(" got led %02h run %0d prog %0d fast %0d",
                 got.led_byte, got.is_running, got.program_now, got.fast_mode);
      end
    end
  endfunction

  function int unsigned pending();
    return expected_status.size();
  endfunction
endclass

module led_pattern_sequencer_top_test;
  import lps_pkg::*;

  // receiver stall styles, one per phase
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_LIGHT,
    RX_PERIODIC,
    RX_HEAVY
  } rx_mode_e;

  // directed opening, bits are {speed, program, run}, 0 = pressed
  // with a debounce depth of one every pair of equal samples is taken
  localparam logic [2:0] OPENING_SEQ [25] = '{
    3'b111, 3'b110, 3'b110, 3'b111, 3'b111,   // run toggles
    3'b101, 3'b101, 3'b111, 3'b111,           // program steps on
    3'b011, 3'b011, 3'b111, 3'b111,           // speed toggles
    3'b000, 3'b000, 3'b111, 3'b111,           // all three at once: run toggles back
    3'b000, 3'b000, 3'b111, 3'b111,           // all three again
    3'b101, 3'b101,                           // program steps on
    3'b110, 3'b110                            // run toggles again
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [LPS_ADDR_W-1:0] paddr;
  logic [LPS_DATA_W-1:0] pwdata;
  logic [LPS_DATA_W-1:0] prdata;
  logic                  pready;

  lps_in_if  in_if ();
  lps_out_if out_if ();

  chaser_scoreboard sb = new();

  // sender side button model: current level and samples left at that level
  logic [2:0]  btn_level = 3'b111;
  int unsigned btn_hold [3] = '{0, 0, 0};

  // receiver controls, set by the main sequence
  rx_mode_e    rx_mode = RX_STEADY;
  int unsigned hold_req = 0;

  led_pattern_sequencer_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // both handshakes sampled at the edge, results checked before the
  // new tick is noted since a result always belongs to an earlier tick
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_status('{led_byte: out_if.led_byte, is_running: out_if.is_running,
                          program_now: out_if.program_now, fast_mode: out_if.fast_mode});
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        logic [2:0] raw;
        raw[BTN_RUN]   = in_if.run_button;
        raw[BTN_PROG]  = in_if.program_button;
        raw[BTN_SPEED] = in_if.speed_button;
        sb.note_tick(raw);
      end
    end
  end

  // receiver: a long hold-off when asked, otherwise the phase's stall style
  initial begin
    int unsigned hold_left;
    int unsigned cyc;
    hold_left = 0;
    cyc = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STEADY:   out_if.ready <= 1'b1;
          RX_LIGHT:    out_if.ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_if.ready <= ((cyc % 7) >= 3);
          default:     out_if.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // offer one tick and return at the edge where it is taken
  task automatic send_tick(input logic [2:0] lvl);
    in_if.valid          <= 1'b1;
    in_if.run_button     <= lvl[BTN_RUN];
    in_if.program_button <= lvl[BTN_PROG];
    in_if.speed_button   <= lvl[BTN_SPEED];
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  // sender gap, payload scrambled while nothing is offered
  task automatic idle_cycles(input int unsigned n);
    in_if.valid          <= 1'b0;
    in_if.run_button     <= 1'($urandom());
    in_if.program_button <= 1'($urandom());
    in_if.speed_button   <= 1'($urandom());
    repeat (n) @(posedge clk_i);
  endtask

  // stop offering and wait for every expected transaction to come out
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // apb write: setup then access, taken at the access edge
  task automatic write_reg(input lps_reg_e idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(input logic [7:0] slow, input logic [7:0] fast,
                              input logic [7:0] need);
    write_reg(REG_SLOW_PERIOD, slow);
    write_reg(REG_FAST_PERIOD, fast);
    write_reg(REG_DEBOUNCE_NEED, need);
  endtask

  // mostly clean presses and releases held long enough to pass the
  // debouncer, some bounces, some very long holds and a little noise
  task automatic run_random_ticks(input int unsigned count, input int unsigned need,
                                  input bit gappy);
    int unsigned depth;
    int unsigned burst_left;
    int unsigned pick;
    logic [2:0]  lvl;
    depth = (need == 0) ? 1 : need;
    burst_left = $urandom_range(1, 24);
    for (int unsigned n = 0; n < count; n++) begin
      for (int b = 0; b < 3; b++) begin
        if (btn_hold[b] == 0) begin
          btn_level[b] = !btn_level[b];
          pick = $urandom_range(0, 19);
          if (pick < 3)
            btn_hold[b] = $urandom_range(1, 2);
          else if (pick < 5)
            btn_hold[b] = $urandom_range(depth + 1, depth + 300);
          else
            btn_hold[b] = $urandom_range(depth + 1, depth + 6);
        end
        btn_hold[b]--;
      end
      lvl = btn_level;
      if ($urandom_range(0, 19) == 0) lvl[$urandom_range(0, 2)] ^= 1'b1;
      send_tick(lvl);
      if (gappy) begin
        burst_left--;
        if (burst_left == 0) begin
          idle_cycles($urandom_range(1, 8));
          burst_left = $urandom_range(1, 24);
        end
      end
    end
  endtask

  initial begin
    in_if.valid          = 1'b0;
    in_if.run_button     = 1'b1;
    in_if.program_button = 1'b1;
    in_if.speed_button   = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the registers, light output stalls
    rx_mode = RX_LIGHT;
    run_random_ticks(150, 32'(DEBOUNCE_NEED_RST), 1'b1);
    wait_drain();

    // directed opening: short periods and single-sample debounce
    program_regs(8'd2, 8'd1, 8'd1);
    rx_mode = RX_STEADY;
    foreach (OPENING_SEQ[i]) send_tick(OPENING_SEQ[i]);
    wait_drain();

    // zero slow period counts a full wrap, zero debounce acts like one
    program_regs(8'd0, 8'd255, 8'd0);
    rx_mode = RX_PERIODIC;
    run_random_ticks(300, 0, 1'b1);
    wait_drain();

    // deepest debounce and a slow period of 255, no idling on either side
    program_regs(8'd255, 8'd1, 8'd255);
    rx_mode = RX_STEADY;
    run_random_ticks(400, 255, 1'b0);
    wait_drain();

    // long receiver hold-off while ticks keep coming, input must back up
    program_regs(8'd7, 8'd3, 8'd3);
    rx_mode = RX_LIGHT;
    run_random_ticks(100, 3, 1'b1);
    hold_req = 400;
    run_random_ticks(300, 3, 1'b0);
    wait_drain();

    // random moderate settings, heavy stalls, a full drain halfway
    begin
      logic [7:0] need;
      need = 8'($urandom_range(1, 8));
      program_regs(8'($urandom_range(1, 40)), 8'($urandom_range(1, 20)), need);
      rx_mode = RX_HEAVY;
      run_random_ticks(175, 32'(need), 1'b1);
      wait_drain();
      run_random_ticks(175, 32'(need), 1'b1);
      wait_drain();
    end

    // step on every tick at slow speed
    program_regs(8'd1, 8'd2, 8'd2);
    rx_mode = RX_PERIODIC;
    run_random_ticks(300, 2, 1'b1);
    wait_drain();

    // idle on to catch anything extra coming out
    repeat (16) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
